// File: rtl/core/timeout_framed_sensor_receiver_defines.svh
// assertion helpers for the timeout framed sensor receiver
`ifndef TIMEOUT_FRAMED_SENSOR_RECEIVER_DEFINES_SVH
`define TIMEOUT_FRAMED_SENSOR_RECEIVER_DEFINES_SVH

// same-cycle implication
`define TFSR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfsr assertion failed");

// next-cycle implication
`define TFSR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfsr assertion failed");

`endif

// File: rtl/core/tfsr_pkg.sv
package tfsr_pkg;

   localparam int unsigned COUNT_W = 8;
   localparam int unsigned DATA_W  = 16;

   localparam logic [COUNT_W-1:0] FRAME_LEN    = 8'd9;
   localparam logic [COUNT_W-1:0] BUFFER_BYTES = 8'd128;

   localparam logic [DATA_W-1:0] TIMEOUT_RESET = 16'd80;
   localparam logic [DATA_W-1:0] OFFSET_RESET  = 16'd0;

   typedef enum logic {
      ACT_BYTE = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   typedef enum logic {
      CSR_IDLE_TIMEOUT   = 1'b0,
      CSR_READING_OFFSET = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic               frame_good;
      logic [COUNT_W-1:0] byte_count;
      logic [DATA_W-1:0]  held_reading;
   } rsp_type;

endpackage

// File: rtl/core/timeout_framed_sensor_receiver.sv
// timeout framed sensor receiver
// req channel: one word per received uart byte (action byte) or per 50 us
//    timer tick (action tick). bytes open a frame and restart the idle
//    counter; ticks advance it while a frame is open.
// rsp channel: one word per closed frame with the checksum verdict, the
//    saturated byte count and the held (offset compensated) reading.
// csr port: write enable, index and 16-bit data; index 0 is the idle
//    timeout in ticks, index 1 the signed reading offset.
// path: the word for the tick that closes a frame passes the input register
//    and then the result register before it shows on rsp.
// throughput: one req word per cycle unless rsp stalls; the checksum is
//    a running value so each word needs a single pass through the update logic.
// reset clears the frame state, the held reading and the csr registers
//    (timeout 80, offset 0) and empties both registers.
// when rsp_ready is low the result word holds; the input register still
//    takes one more word, then req_ready drops until the result is taken.
module timeout_framed_sensor_receiver (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tfsr_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tfsr_pkg::rsp_type        rsp_data,
   input  logic                     csr_wr_en,
   input  tfsr_pkg::csr_index_type  csr_index,
   input  logic [15:0]              csr_wdata
);

   logic                               in_valid_ff, in_valid_in;
   tfsr_pkg::req_type                  in_ff, in_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   tfsr_pkg::rsp_type                  rsp_ff, rsp_in;

   logic [tfsr_pkg::DATA_W-1:0]        timeout_ff, timeout_in;
   logic [tfsr_pkg::DATA_W-1:0]        offset_ff, offset_in;

   logic [tfsr_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [tfsr_pkg::DATA_W-1:0]        idle_ff, idle_in;
   logic                               open_ff, open_in;
   logic [tfsr_pkg::DATA_W-1:0]        reading_ff, reading_in;
   logic [7:0]                         chk_ff, chk_in;
   logic                               sum_ok_ff, sum_ok_in;
   logic [7:0]                         hi_ff, hi_in;
   logic [7:0]                         lo_ff, lo_in;

   logic                               fire;
   logic                               close;
   logic                               good;
   logic [tfsr_pkg::DATA_W-1:0]        idle_next;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign idle_next = 16'(idle_ff + 16'd1);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_in       = req_data;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      timeout_in = timeout_ff;
      offset_in  = offset_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tfsr_pkg::CSR_IDLE_TIMEOUT:   timeout_in = csr_wdata;
            tfsr_pkg::CSR_READING_OFFSET: offset_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      count_in   = count_ff;
      idle_in    = idle_ff;
      open_in    = open_ff;
      reading_in = reading_ff;
      chk_in     = chk_ff;
      sum_ok_in  = sum_ok_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      close      = 1'b0;
      good       = 1'b0;
      if (fire) begin
         if (in_ff.action == tfsr_pkg::ACT_BYTE) begin
            // running checksum over the first eight bytes, checked against the ninth
            if (count_ff == 8'd0) begin
               chk_in = in_ff.rx_byte;
            end else if (count_ff < 8'(tfsr_pkg::FRAME_LEN - 8'd1)) begin
               chk_in = 8'(chk_ff - in_ff.rx_byte);
            end
            if (count_ff == 8'(tfsr_pkg::FRAME_LEN - 8'd1)) begin
               sum_ok_in = (8'(chk_ff + 8'd1) == in_ff.rx_byte);
            end
            if (count_ff == 8'd2) begin
               hi_in = in_ff.rx_byte;
            end
            if (count_ff == 8'd3) begin
               lo_in = in_ff.rx_byte;
            end
            if (count_ff < tfsr_pkg::BUFFER_BYTES) begin
               count_in = 8'(count_ff + 8'd1);
            end
            idle_in = '0;
            open_in = 1'b1;
         end else if (!open_ff) begin
            idle_in = '0;
         end else if (idle_next < timeout_ff) begin
            idle_in = idle_next;
         end else begin
            close    = 1'b1;
            open_in  = 1'b0;
            idle_in  = '0;
            count_in = '0;
            good     = (count_ff >= tfsr_pkg::FRAME_LEN) && sum_ok_ff;
            if (good) begin
               reading_in = 16'({hi_ff, lo_ff} + offset_ff);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (close) begin
         rsp_valid_in            = 1'b1;
         rsp_in.frame_good       = good;
         rsp_in.byte_count       = count_ff;
         rsp_in.held_reading     = reading_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= tfsr_pkg::TIMEOUT_RESET;
         offset_ff    <= tfsr_pkg::OFFSET_RESET;
         count_ff     <= '0;
         idle_ff      <= '0;
         open_ff      <= 1'b0;
         reading_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         timeout_ff   <= timeout_in;
         offset_ff    <= offset_in;
         count_ff     <= count_in;
         idle_ff      <= idle_in;
         open_ff      <= open_in;
         reading_ff   <= reading_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff     <= in_in;
      rsp_ff    <= rsp_in;
      chk_ff    <= chk_in;
      sum_ok_ff <= sum_ok_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
   end

endmodule

// File: rtl/core/tfsr_checker.sv
`include "timeout_framed_sensor_receiver_defines.svh"

module tfsr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input tfsr_pkg::req_type        req_data,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input tfsr_pkg::rsp_type        rsp_data,
   input logic                     csr_wr_en,
   input tfsr_pkg::csr_index_type  csr_index,
   input logic [15:0]              csr_wdata
);

   // a stalled result word stays offered
   `TFSR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // reset leaves no result pending
   `TFSR_ASSERT_NOW(a_rsp_reset, clock, reset, $past(reset), !rsp_valid)

   // a good frame always carries the full checksum span
   `TFSR_ASSERT_NOW(a_good_len, clock, reset, rsp_valid && rsp_data.frame_good,
      rsp_data.byte_count >= tfsr_pkg::FRAME_LEN)

   // a closed frame had at least one byte and the count saturates
   `TFSR_ASSERT_NOW(a_count_range, clock, reset, rsp_valid,
      (rsp_data.byte_count != 8'd0) && (rsp_data.byte_count <= tfsr_pkg::BUFFER_BYTES))

endmodule

bind timeout_framed_sensor_receiver tfsr_checker u_tfsr_checker (.*);
